### design/dhrb_pkg.sv
// Package for the decimating history ring buffer.
// Holds field widths, divider sizes, register indexes and the controller state type.
// No dependencies.
package dhrb_pkg;

	localparam int SAMPLE_W = 32;
	localparam int MS_W     = 16;
	localparam int RATE_W   = 14;
	localparam int PRE_W    = 8;
	localparam int CFG_W    = 14;
	localparam int CNT9_W   = PRE_W + 1;

	localparam int MS_PER_S = 1000;
	localparam int NUM_W    = RATE_W + MS_W;
	localparam int DEN_W    = PRE_W + 10;
	localparam int STEP_W   = $clog2(NUM_W);

	localparam logic REG_RATE     = 1'b0;
	localparam logic REG_PRESCALE = 1'b1;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_WAIT,
		ST_ADDR,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic we;
		logic re;
	} store_ctl_t;

endpackage

### design/dhrb_div.sv
// Restoring divider, one quotient bit per cycle, for the lookback index.
// Depends on dhrb_pkg for operand widths.
module dhrb_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dhrb_pkg::NUM_W-1:0] num,
	input  logic [dhrb_pkg::DEN_W-1:0] den,
	output logic                       done,
	output logic [dhrb_pkg::NUM_W-1:0] quot
);

	logic                        busy_q;
	logic                        done_q;
	logic [dhrb_pkg::STEP_W-1:0] step_q;
	logic [dhrb_pkg::DEN_W-1:0]  rem_q;
	logic [dhrb_pkg::DEN_W-1:0]  den_q;
	logic [dhrb_pkg::NUM_W-1:0]  quo_q;
	logic [dhrb_pkg::DEN_W:0]    rem_w;
	logic [dhrb_pkg::DEN_W:0]    rem_n;
	logic                        ge;
	logic                        last;

	always_comb begin
		rem_w = {rem_q, quo_q[dhrb_pkg::NUM_W-1]};
		ge    = rem_w >= {1'b0, den_q};
		rem_n = ge ? (rem_w - {1'b0, den_q}) : rem_w;
		last  = step_q == dhrb_pkg::STEP_W'(dhrb_pkg::NUM_W - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + dhrb_pkg::STEP_W'(1);
				if (last) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[dhrb_pkg::NUM_W-2:0], ge};
			rem_q <= rem_n[dhrb_pkg::DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

### design/dhrb_store.sv
// History memory: one write and one registered read port, cleared by a sweep after reset.
// Depends on dhrb_pkg for the port control struct.
module dhrb_store #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dhrb_pkg::store_ctl_t         ctl,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  logic [DATA_WIDTH-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output logic [DATA_WIDTH-1:0]        rdata,
	output logic                         clearing
);

	localparam int AW = $clog2(DEPTH);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;
	logic                  clear_q;
	logic [AW-1:0]         clr_addr_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;

	always_comb begin
		mem_we    = clear_q || ctl.we;
		mem_waddr = clear_q ? clr_addr_q : waddr;
		mem_wdata = clear_q ? '0 : wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) clear_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (ctl.re) rdata_q <= mem[raddr];
	end

	assign rdata    = rdata_q;
	assign clearing = clear_q;

endmodule

### design/decimating_history_ring_buffer.sv
// Top level of the decimating history ring buffer.
// Depends on dhrb_pkg, dhrb_store and dhrb_div.
//
// Usage:
//   Input channel (in_valid/in_stall) carries cmd, sample and lookback_ms.
//   A push (cmd 0) gives no result item; the sample is
//   written at the head slot, which advances once per prescale period of pushes.
//   A read (cmd 1) gives one result item (data, too_old) on the output channel
//   after it is accepted: the rate*ms product, divider start, the bit-serial
//   divider that forms the lookback index, then slot select, memory read and
//   output load. in_stall stays high while a read is in progress, so a read is
//   taken only after the last one is done; pushes run at one per cycle while
//   in_stall is low.
//   The output register parts the two sides: pushes and a new read are taken
//   while a result still waits; a finished read holds before the memory read
//   until the output register is free.
//   After reset the memory is cleared by a sweep, one entry a cycle, with
//   in_stall high; configuration writes are taken throughout.
//   Configuration: cfg_we with cfg_index 0 (sample rate) or 1 (prescale).
module decimating_history_ring_buffer #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [dhrb_pkg::SAMPLE_W-1:0] sample,
	input  logic [dhrb_pkg::MS_W-1:0]     lookback_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dhrb_pkg::SAMPLE_W-1:0] data,
	output logic                          too_old,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [dhrb_pkg::CFG_W-1:0]    cfg_data
);

	localparam int AW = $clog2(DEPTH);

	dhrb_pkg::state_t     state_q;
	dhrb_pkg::state_t     state_d;
	dhrb_pkg::store_ctl_t ctl;

	logic [dhrb_pkg::RATE_W-1:0] rate_q;
	logic [dhrb_pkg::PRE_W-1:0]  prescale_q;
	logic [AW-1:0]               head_q;
	logic [dhrb_pkg::PRE_W-1:0]  count_q;
	logic [dhrb_pkg::MS_W-1:0]   ms_q;
	logic [dhrb_pkg::NUM_W-1:0]  num_q;
	logic [dhrb_pkg::DEN_W-1:0]  den_q;
	logic [AW-1:0]               slot_q;
	logic                        old_q;
	logic                        out_valid_q;
	logic [dhrb_pkg::SAMPLE_W-1:0] data_q;
	logic                        too_old_q;

	logic                        accept;
	logic                        push;
	logic [dhrb_pkg::PRE_W-1:0]  eff;
	logic [dhrb_pkg::CNT9_W-1:0] cnt_inc;
	logic                        adv;
	logic [AW-1:0]               head_nx;
	logic [dhrb_pkg::PRE_W-1:0]  count_nx;
	logic                        div_start;
	logic                        div_done;
	logic [dhrb_pkg::NUM_W-1:0]  quot;
	logic                        is_old;
	logic [AW-1:0]               idx;
	logic [AW:0]                 wrap_sum;
	logic [AW-1:0]               slot_nx;
	logic                        out_free;
	logic [DATA_WIDTH-1:0]       rdata;
	logic                        clearing;

	always_comb begin
		accept   = in_valid && !in_stall;
		push     = accept && (cmd == dhrb_pkg::CMD_PUSH);
		eff      = (prescale_q == '0) ? dhrb_pkg::PRE_W'(1) : prescale_q;
		cnt_inc  = {1'b0, count_q} + dhrb_pkg::CNT9_W'(1);
		adv      = cnt_inc >= {1'b0, eff};
		if (adv) begin
			head_nx  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
			count_nx = '0;
		end else begin
			head_nx  = head_q;
			count_nx = cnt_inc[dhrb_pkg::PRE_W-1:0];
		end
		is_old   = quot >= dhrb_pkg::NUM_W'(DEPTH);
		idx      = is_old ? AW'(DEPTH - 1) : quot[AW-1:0];
		wrap_sum = {1'b0, head_q} + (AW+1)'(DEPTH) - {1'b0, idx};
		slot_nx  = (head_q >= idx) ? (head_q - idx) : wrap_sum[AW-1:0];
		out_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		ctl.we    = push;
		ctl.re    = 1'b0;
		unique case (state_q)
			dhrb_pkg::ST_CLEAR: begin
				if (!clearing) state_d = dhrb_pkg::ST_IDLE;
			end
			dhrb_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (accept && cmd == dhrb_pkg::CMD_READ) state_d = dhrb_pkg::ST_MUL;
			end
			dhrb_pkg::ST_MUL: state_d = dhrb_pkg::ST_DIV;
			dhrb_pkg::ST_DIV: begin
				div_start = 1'b1;
				state_d   = dhrb_pkg::ST_WAIT;
			end
			dhrb_pkg::ST_WAIT: begin
				if (div_done) state_d = dhrb_pkg::ST_ADDR;
			end
			dhrb_pkg::ST_ADDR: begin
				if (out_free) begin
					ctl.re  = 1'b1;
					state_d = dhrb_pkg::ST_LOAD;
				end
			end
			dhrb_pkg::ST_LOAD: state_d = dhrb_pkg::ST_IDLE;
			default: state_d = dhrb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dhrb_pkg::ST_CLEAR;
			rate_q      <= dhrb_pkg::RATE_W'(100);
			prescale_q  <= dhrb_pkg::PRE_W'(1);
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					dhrb_pkg::REG_RATE:     rate_q     <= cfg_data;
					dhrb_pkg::REG_PRESCALE: prescale_q <= cfg_data[dhrb_pkg::PRE_W-1:0];
					default: ;
				endcase
			end
			if (push) begin
				head_q  <= head_nx;
				count_q <= count_nx;
			end
			if (state_q == dhrb_pkg::ST_LOAD) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) ms_q <= lookback_ms;
		if (state_q == dhrb_pkg::ST_MUL) begin
			num_q <= dhrb_pkg::NUM_W'(rate_q) * dhrb_pkg::NUM_W'(ms_q);
			den_q <= dhrb_pkg::DEN_W'(eff) * dhrb_pkg::DEN_W'(dhrb_pkg::MS_PER_S);
		end
		if (state_q == dhrb_pkg::ST_WAIT && div_done) begin
			slot_q <= slot_nx;
			old_q  <= is_old;
		end
		if (state_q == dhrb_pkg::ST_LOAD) begin
			data_q    <= dhrb_pkg::SAMPLE_W'(rdata);
			too_old_q <= old_q;
		end
	end

	dhrb_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.waddr    (head_nx),
		.wdata    (DATA_WIDTH'(sample)),
		.raddr    (slot_q),
		.rdata    (rdata),
		.clearing (clearing)
	);

	dhrb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign too_old   = too_old_q;

endmodule

### design/dhrb_checker.sv
// Port-level checks for the decimating history ring buffer, bound to the top level.
// Depends on dhrb_pkg for field widths and command codes.
module dhrb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          cmd,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [dhrb_pkg::SAMPLE_W-1:0] data,
	input logic                          too_old
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(data) && $stable(too_old))
		else $error("stalled result item changed");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == dhrb_pkg::CMD_READ |=> in_stall)
		else $error("input taken while a read is in progress");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result item appeared right after an accepted item");

endmodule

bind decimating_history_ring_buffer dhrb_checker u_dhrb_checker (.*);

### dv/tb.sv
// Self-checking testbench for decimating_history_ring_buffer.
// Keeps its own copy of the decimated history and the lookback arithmetic and checks every read.
// Depends on dhrb_pkg and the decimating_history_ring_buffer RTL.
module tb;

	localparam int DEPTH       = 1024;
	localparam int SLOT_W      = $clog2(DEPTH);
	localparam int RX_HOLD     = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct packed {
		logic [dhrb_pkg::SAMPLE_W-1:0] data;
		logic                          too_old;
	} read_t;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	// sel is cmd for an item, register index for a write; val is sample or register value
	typedef struct {
		row_kind_t                     kind;
		logic                          sel;
		logic [dhrb_pkg::SAMPLE_W-1:0] val;
		logic [dhrb_pkg::MS_W-1:0]     ms;
		bit                            typed;
		read_t                         want;
	} row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic                          cmd;
	logic [dhrb_pkg::SAMPLE_W-1:0] sample;
	logic [dhrb_pkg::MS_W-1:0]     lookback_ms;
	logic                          out_valid;
	logic                          out_stall;
	logic [dhrb_pkg::SAMPLE_W-1:0] data;
	logic                          too_old;
	logic                          cfg_we;
	logic                          cfg_index;
	logic [dhrb_pkg::CFG_W-1:0]    cfg_data;

	decimating_history_ring_buffer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.sample(sample),
		.lookback_ms(lookback_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data(data),
		.too_old(too_old),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [dhrb_pkg::SAMPLE_W-1:0] hist_mem [DEPTH];
	logic [SLOT_W-1:0]             hist_head;
	logic [dhrb_pkg::PRE_W-1:0]    hist_count;
	logic [dhrb_pkg::RATE_W-1:0]   cfg_rate;
	logic [dhrb_pkg::PRE_W-1:0]    cfg_pre;

	read_t expected_reads [$];
	row_t  dir_rows [$];

	int  mismatches;
	int  n_push;
	int  n_read;
	int  n_too_old;
	int  n_cfg;
	int  idle_cycles;
	bit  tx_steady;
	bit  rx_steady;
	bit  hold_req;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [dhrb_pkg::PRE_W-1:0] eff_pre();
		return (cfg_pre == '0) ? dhrb_pkg::PRE_W'(1) : cfg_pre;
	endfunction

	function automatic void hist_push(logic [dhrb_pkg::SAMPLE_W-1:0] s);
		logic [dhrb_pkg::PRE_W:0] cnt;
		cnt = {1'b0, hist_count} + 1'b1;
		if (cnt >= {1'b0, eff_pre()}) begin
			cnt = '0;
			hist_head = hist_head + 1'b1;
		end
		hist_count = cnt[dhrb_pkg::PRE_W-1:0];
		hist_mem[hist_head] = s;
	endfunction

	function automatic read_t hist_lookup(logic [dhrb_pkg::MS_W-1:0] ms);
		longint unsigned num;
		longint unsigned den;
		longint unsigned idx;
		logic [SLOT_W-1:0] slot;
		read_t r;
		num = longint'(cfg_rate) * longint'(ms);
		den = longint'(eff_pre()) * dhrb_pkg::MS_PER_S;
		idx = num / den;
		r.too_old = (idx >= DEPTH);
		if (r.too_old)
			idx = DEPTH - 1;
		slot = hist_head - idx[SLOT_W-1:0];
		r.data = hist_mem[slot];
		return r;
	endfunction

	// lookback range that mostly lands inside the stored history
	function automatic logic [dhrb_pkg::MS_W-1:0] near_span();
		longint unsigned s;
		if (cfg_rate == '0)
			return '1;
		s = (64'd1100 * eff_pre() * dhrb_pkg::MS_PER_S) / cfg_rate;
		return (s > 65535) ? '1 : s[dhrb_pkg::MS_W-1:0];
	endfunction

	function automatic row_t mk(row_kind_t k, logic sel, logic [dhrb_pkg::SAMPLE_W-1:0] val,
			logic [dhrb_pkg::MS_W-1:0] ms, bit typed, logic [dhrb_pkg::SAMPLE_W-1:0] d,
			logic o);
		row_t r;
		r.kind = k;
		r.sel = sel;
		r.val = val;
		r.ms = ms;
		r.typed = typed;
		r.want.data = d;
		r.want.too_old = o;
		return r;
	endfunction

	task automatic report(string what, logic [dhrb_pkg::SAMPLE_W-1:0] exp_v,
			logic [dhrb_pkg::SAMPLE_W-1:0] got_v);
		if (mismatches < 100)
			$display("tb: mismatch %s at %0t: expected %h got %h", what, $time, exp_v, got_v);
		mismatches++;
	endtask

	task automatic send_item(logic c, logic [dhrb_pkg::SAMPLE_W-1:0] s,
			logic [dhrb_pkg::MS_W-1:0] ms, bit typed, read_t want);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		sample <= s;
		lookback_ms <= ms;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (c == dhrb_pkg::CMD_PUSH) begin
			hist_push(s);
			n_push++;
		end else begin
			n_read++;
			expected_reads.push_back(typed ? want : hist_lookup(ms));
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_reads.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_reg(logic sel, logic [dhrb_pkg::CFG_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == dhrb_pkg::REG_RATE)
			cfg_rate = val[dhrb_pkg::RATE_W-1:0];
		else
			cfg_pre = val[dhrb_pkg::PRE_W-1:0];
		n_cfg++;
	endtask

	task automatic run_phase(int n_items, int push_pct);
		read_t none;
		logic [dhrb_pkg::MS_W-1:0] ms;
		none = '0;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 99) < push_pct) begin
				send_item(dhrb_pkg::CMD_PUSH, $urandom, dhrb_pkg::MS_W'($urandom), 1'b0, none);
			end else begin
				if ($urandom_range(0, 9) < 7)
					ms = dhrb_pkg::MS_W'($urandom_range(0, near_span()));
				else
					ms = dhrb_pkg::MS_W'($urandom);
				send_item(dhrb_pkg::CMD_READ, $urandom, ms, 1'b0, none);
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		read_t w;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_reads.size() == 0) begin
				report("unexpected result", '0, data);
			end else begin
				w = expected_reads.pop_front();
				if (data !== w.data)
					report("data", w.data, data);
				if (too_old !== w.too_old)
					report("too_old", dhrb_pkg::SAMPLE_W'(w.too_old),
						dhrb_pkg::SAMPLE_W'(too_old));
				if (w.too_old)
					n_too_old++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0) || cfg_we === 1'b1)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: no handshake for %0d cycles", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : receiver
		int n;
		out_stall = 1'b0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (RX_HOLD) @(posedge clk);
			end else begin
				n = rx_steady ? 0 : $urandom_range(0, 11);
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = dhrb_pkg::CMD_PUSH;
		sample = '0;
		lookback_ms = '0;
		cfg_we = 1'b0;
		cfg_index = dhrb_pkg::REG_RATE;
		cfg_data = '0;
		mismatches = 0;
		n_push = 0;
		n_read = 0;
		n_too_old = 0;
		n_cfg = 0;
		idle_cycles = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		hold_req = 1'b0;
		for (int i = 0; i < DEPTH; i++)
			hist_mem[i] = '0;
		hist_head = '0;
		hist_count = '0;
		cfg_rate = dhrb_pkg::RATE_W'(100);
		cfg_pre = dhrb_pkg::PRE_W'(1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// cleared store, then too-old reads, zero rate, zero and lowered prescale
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'hDEADBEEF, 16'd0,
			1, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'h0, 16'hFFFF,
			1, 32'h0, 1'b1));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_PUSH, 32'hFFFFFFFF, 16'hFFFF,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'h0, 16'd0,
			1, 32'hFFFFFFFF, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_PUSH, 32'h0, 16'h5555,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_PUSH, 32'hA5A5A5A5, 16'hAAAA,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_PUSH, 32'h5A5A5A5A, 16'h0,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'h1, 16'd10,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'h2, 16'd30,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'h3, 16'd10239,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'h4, 16'd10240,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_CFG, dhrb_pkg::REG_RATE, 32'h0, 16'd0,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'hFFFFFFFF, 16'hFFFF,
			1, 32'h5A5A5A5A, 1'b0));
		dir_rows.push_back(mk(ROW_CFG, dhrb_pkg::REG_RATE, 32'h3FFF, 16'd0,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_CFG, dhrb_pkg::REG_PRESCALE, 32'h0, 16'd0,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_PUSH, 32'h13579BDF, 16'h1234,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'h0, 16'd1,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'h0, 16'hFFFF,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_CFG, dhrb_pkg::REG_PRESCALE, 32'hFF, 16'd0,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_PUSH, 32'h11111111, 16'd7,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_PUSH, 32'h22222222, 16'd7,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_PUSH, 32'h33333333, 16'd7,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'h0, 16'd0,
			1, 32'h33333333, 1'b0));
		dir_rows.push_back(mk(ROW_CFG, dhrb_pkg::REG_PRESCALE, 32'h3F02, 16'd0,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_PUSH, 32'h44444444, 16'd7,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'h0, 16'd0,
			0, 32'h0, 1'b0));
		dir_rows.push_back(mk(ROW_ITEM, dhrb_pkg::CMD_READ, 32'h0, 16'hFFFF,
			0, 32'h0, 1'b0));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				set_reg(dir_rows[i].sel, dir_rows[i].val[dhrb_pkg::CFG_W-1:0]);
			else
				send_item(dir_rows[i].sel, dir_rows[i].val, dir_rows[i].ms,
					dir_rows[i].typed, dir_rows[i].want);
		end

		set_reg(dhrb_pkg::REG_RATE, 14'd100);
		set_reg(dhrb_pkg::REG_PRESCALE, 14'd1);
		run_phase(115, 60);
		set_reg(dhrb_pkg::REG_RATE, 14'd1);
		run_phase(110, 60);
		set_reg(dhrb_pkg::REG_RATE, 14'd10000);
		run_phase(110, 60);
		set_reg(dhrb_pkg::REG_RATE, 14'h3FFF);
		set_reg(dhrb_pkg::REG_PRESCALE, 14'd255);
		run_phase(110, 60);

		set_reg(dhrb_pkg::REG_RATE, 14'd1000);
		set_reg(dhrb_pkg::REG_PRESCALE, 14'd0);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		run_phase(110, 60);
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		set_reg(dhrb_pkg::REG_RATE, 14'd0);
		set_reg(dhrb_pkg::REG_PRESCALE, 14'd7);
		run_phase(110, 60);

		// build up the prescale count, then lower the prescale under it
		set_reg(dhrb_pkg::REG_RATE, dhrb_pkg::CFG_W'($urandom_range(1, 16383)));
		set_reg(dhrb_pkg::REG_PRESCALE, 14'd200);
		run_phase(115, 80);
		set_reg(dhrb_pkg::REG_PRESCALE, {6'($urandom), 8'd3});
		tx_steady = 1'b1;
		hold_req = 1'b1;
		run_phase(110, 30);
		tx_steady = 1'b0;

		repeat (3) begin
			set_reg(dhrb_pkg::REG_RATE, dhrb_pkg::CFG_W'($urandom_range(0, 16383)));
			set_reg(dhrb_pkg::REG_PRESCALE, dhrb_pkg::CFG_W'($urandom_range(0, 16383)));
			run_phase(110, 60);
		end

		drain();
		while (expected_reads.size() != 0) begin
			report("missing result", expected_reads[0].data, '0);
			void'(expected_reads.pop_front());
		end
		$display("tb: %0d pushes, %0d reads (%0d too_old), %0d register writes",
			n_push, n_read, n_too_old, n_cfg);
		$display("tb: rate and prescale swept incl. zero and lowered, long hold; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
